>>> hdl/euler321_to_rotation_matrix_unit_assert.svh
// Assertion macros for the Euler 3-2-1 to rotation matrix unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef EULER321_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define EULER321_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define E321_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("e321 assertion failed");
`define E321_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("e321 assertion failed");
`else
`define E321_ASSERT_NOW(lbl, ante, cons)
`define E321_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/e321_pkg.sv
// Shared types and constants for the Euler 3-2-1 rotation matrix unit.
// No dependencies.
package e321_pkg;

    localparam int ANG_W   = 16;
    localparam int R_W     = 36;   // angle in Q30 before reduction
    localparam int CW      = 33;   // CORDIC datapath
    localparam int SC_W    = 23;   // sine/cosine in Q20
    localparam int PROD_W  = 46;
    localparam int LO_W    = 47;
    localparam int Q60_W   = 72;
    localparam int OUT_W   = 16;
    localparam int STEPS   = 20;
    localparam int K_W     = 3;
    localparam int N_ENT   = 9;
    localparam int LANE_LAT  = 23;
    localparam int MERGE_LAT = 4;

    localparam logic signed [R_W-1:0] HALF_PI_R    = 36'sd1686629713;
    localparam logic signed [R_W-1:0] QUARTER_PI_R = 36'sd843314856;
    localparam logic [R_W-1:0]        HALF_PI_U    = 36'd1686629713;
    localparam logic signed [CW-1:0]  CORDIC_X0    = 33'sd652032874;

    typedef logic signed [SC_W-1:0]  sc_t;
    typedef logic signed [OUT_W-1:0] q14_t;

    typedef struct packed {
        sc_t sin_v;
        sc_t cos_v;
    } sincos_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:    v = 33'sh03243F6A8;
            5'd1:    v = 33'sh01DAC6705;
            5'd2:    v = 33'sh00FADBAFC;
            5'd3:    v = 33'sh007F56EA6;
            5'd4:    v = 33'sh003FEAB76;
            5'd5:    v = 33'sh001FFD55B;
            5'd6:    v = 33'sh000FFFAAA;
            5'd7:    v = 33'sh0007FFF55;
            5'd8:    v = 33'sh0003FFFEA;
            5'd9:    v = 33'sh0001FFFFD;
            5'd10:   v = 33'sh0000FFFFF;
            5'd11:   v = 33'sh00007FFFF;
            5'd12:   v = 33'sh00003FFFF;
            5'd13:   v = 33'sh00001FFFF;
            5'd14:   v = 33'sh00000FFFF;
            5'd15:   v = 33'sh000007FFF;
            5'd16:   v = 33'sh000003FFF;
            5'd17:   v = 33'sh000001FFF;
            5'd18:   v = 33'sh000000FFF;
            5'd19:   v = 33'sh0000007FF;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/e321_sincos_lane.sv
// One sine/cosine lane: quarter-turn reduction, 20-stage CORDIC, quadrant fix-up.
// Depends on e321_pkg.
module e321_sincos_lane (
    input  logic                               clk,
    input  logic                               advance,
    input  logic signed [e321_pkg::ANG_W-1:0]  angle,
    output e321_pkg::sincos_t                  result
);
    import e321_pkg::*;

    // reduction, first half: subtract quarter turns
    logic signed [R_W-1:0] r_in;
    logic signed [R_W-1:0] th_pos;
    logic [K_W-1:0]        kpos;
    logic signed [R_W-1:0] r1;
    logic signed [R_W-1:0] r1_reg;
    logic [K_W-1:0]        kpos_reg;

    assign r_in = {{(R_W-ANG_W-18){angle[ANG_W-1]}}, angle, 18'b0};

    always_comb
    begin
        th_pos = QUARTER_PI_R;
        kpos   = '0;
        for (int j = 0; j < 6; j++)
        begin
            if (r_in > th_pos)
                kpos = kpos + K_W'(1);
            th_pos = th_pos + HALF_PI_R;
        end
        r1 = r_in - $signed(HALF_PI_U * R_W'(kpos));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            r1_reg   <= r1;
            kpos_reg <= kpos;
        end
    end

    // reduction, second half: add quarter turns back
    logic signed [R_W-1:0] th_neg;
    logic [K_W-1:0]        kneg;
    logic signed [R_W-1:0] r2;

    always_comb
    begin
        th_neg = -QUARTER_PI_R;
        kneg   = '0;
        for (int j = 0; j < 6; j++)
        begin
            if (r1_reg < th_neg)
                kneg = kneg + K_W'(1);
            th_neg = th_neg - HALF_PI_R;
        end
        r2 = r1_reg + $signed(HALF_PI_U * R_W'(kneg));
    end

    logic signed [CW-1:0] x_reg [0:STEPS];
    logic signed [CW-1:0] y_reg [0:STEPS];
    logic signed [CW-1:0] z_reg [0:STEPS];
    logic [1:0]           q_reg [0:STEPS];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0] <= CORDIC_X0;
            y_reg[0] <= '0;
            z_reg[0] <= r2[CW-1:0];
            q_reg[0] <= kpos_reg[1:0] - kneg[1:0];
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = atan_q30(5'(i));

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                if (!z_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    // quadrant map and Q30 -> Q20 rounding
    logic signed [CW-1:0] cs;
    logic signed [CW-1:0] sn;
    logic signed [CW-1:0] cs_rnd;
    logic signed [CW-1:0] sn_rnd;
    sincos_t              result_reg;

    always_comb
    begin
        case (q_reg[STEPS])
            2'd0:
            begin
                cs = x_reg[STEPS];
                sn = y_reg[STEPS];
            end
            2'd1:
            begin
                cs = -y_reg[STEPS];
                sn = x_reg[STEPS];
            end
            2'd2:
            begin
                cs = -x_reg[STEPS];
                sn = -y_reg[STEPS];
            end
            default:
            begin
                cs = y_reg[STEPS];
                sn = -x_reg[STEPS];
            end
        endcase
        cs_rnd = (cs + 33'sd512) >>> 10;
        sn_rnd = (sn + 33'sd512) >>> 10;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.cos_v <= cs_rnd[SC_W-1:0];
            result_reg.sin_v <= sn_rnd[SC_W-1:0];
        end
    end

    assign result = result_reg;

endmodule

>>> hdl/e321_dcm_merge.sv
// Merge stage: combines the three lanes' sines and cosines into the nine
// matrix entries (pair products, split triple products, sums, round, clamp).
// Depends on e321_pkg.
module e321_dcm_merge (
    input  logic              clk,
    input  logic              advance,
    input  e321_pkg::sincos_t yaw,
    input  e321_pkg::sincos_t pitch,
    input  e321_pkg::sincos_t roll,
    output e321_pkg::q14_t    ent [e321_pkg::N_ENT]
);
    import e321_pkg::*;

    localparam logic signed [Q60_W-1:0] ROUND_Q60 = 72'sh00_0000_2000_0000_0000;
    localparam logic signed [Q60_W-1:0] POS_ONE   = 72'sd16384;
    localparam logic signed [Q60_W-1:0] NEG_ONE   = -72'sd16384;

    function automatic q14_t to_q14(input logic signed [Q60_W-1:0] q);
        logic signed [Q60_W-1:0] s;
        s = (q + ROUND_Q60) >>> 46;
        if (s > POS_ONE)
            s = POS_ONE;
        if (s < NEG_ONE)
            s = NEG_ONE;
        return s[OUT_W-1:0];
    endfunction

    // stage 1: all two-factor products
    logic signed [PROD_W-1:0] cycp_reg, sycr_reg, sysr_reg, cycr_reg;
    logic signed [PROD_W-1:0] cysr_reg, srcp_reg, crcp_reg, sycp_reg;
    logic signed [PROD_W-1:0] spsr_reg, spcr_reg;
    sc_t cy1_reg, sy1_reg, sp1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cycp_reg <= yaw.cos_v * pitch.cos_v;
            sycr_reg <= yaw.sin_v * roll.cos_v;
            sysr_reg <= yaw.sin_v * roll.sin_v;
            cycr_reg <= yaw.cos_v * roll.cos_v;
            cysr_reg <= yaw.cos_v * roll.sin_v;
            srcp_reg <= roll.sin_v * pitch.cos_v;
            crcp_reg <= roll.cos_v * pitch.cos_v;
            sycp_reg <= yaw.sin_v * pitch.cos_v;
            spsr_reg <= pitch.sin_v * roll.sin_v;
            spcr_reg <= pitch.sin_v * roll.cos_v;
            cy1_reg  <= yaw.cos_v;
            sy1_reg  <= yaw.sin_v;
            sp1_reg  <= pitch.sin_v;
        end
    end

    // stage 2: triple products as high and low partial products
    logic signed [SC_W-1:0] spsr_hi, spcr_hi;
    logic signed [SC_W:0]   spsr_lo, spcr_lo;
    logic signed [PROD_W-1:0] h_cysr_reg, h_cycr_reg, h_sysr_reg, h_sycr_reg;
    logic signed [LO_W-1:0]   l_cysr_reg, l_cycr_reg, l_sysr_reg, l_sycr_reg;
    logic signed [PROD_W-1:0] cycp2_reg, sycr2_reg, sysr2_reg, cycr2_reg;
    logic signed [PROD_W-1:0] cysr2_reg, srcp2_reg, crcp2_reg, sycp2_reg;
    sc_t sp2_reg;

    assign spsr_hi = spsr_reg[PROD_W-1:SC_W];
    assign spcr_hi = spcr_reg[PROD_W-1:SC_W];
    assign spsr_lo = $signed({1'b0, spsr_reg[SC_W-1:0]});
    assign spcr_lo = $signed({1'b0, spcr_reg[SC_W-1:0]});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            h_cysr_reg <= cy1_reg * spsr_hi;
            h_cycr_reg <= cy1_reg * spcr_hi;
            h_sysr_reg <= sy1_reg * spsr_hi;
            h_sycr_reg <= sy1_reg * spcr_hi;
            l_cysr_reg <= cy1_reg * spsr_lo;
            l_cycr_reg <= cy1_reg * spcr_lo;
            l_sysr_reg <= sy1_reg * spsr_lo;
            l_sycr_reg <= sy1_reg * spcr_lo;
            cycp2_reg  <= cycp_reg;
            sycr2_reg  <= sycr_reg;
            sysr2_reg  <= sysr_reg;
            cycr2_reg  <= cycr_reg;
            cysr2_reg  <= cysr_reg;
            srcp2_reg  <= srcp_reg;
            crcp2_reg  <= crcp_reg;
            sycp2_reg  <= sycp_reg;
            sp2_reg    <= sp1_reg;
        end
    end

    // stage 3: assemble triples in Q60, lift pairs to Q60
    logic signed [Q60_W-1:0] t_cysr_reg, t_cycr_reg, t_sysr_reg, t_sycr_reg;
    logic signed [Q60_W-1:0] q_cycp_reg, q_sycr_reg, q_sysr_reg, q_cycr_reg;
    logic signed [Q60_W-1:0] q_cysr_reg, q_srcp_reg, q_crcp_reg, q_sycp_reg;
    logic signed [Q60_W-1:0] q_sp_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_cysr_reg <= (Q60_W'(h_cysr_reg) <<< SC_W) + Q60_W'(l_cysr_reg);
            t_cycr_reg <= (Q60_W'(h_cycr_reg) <<< SC_W) + Q60_W'(l_cycr_reg);
            t_sysr_reg <= (Q60_W'(h_sysr_reg) <<< SC_W) + Q60_W'(l_sysr_reg);
            t_sycr_reg <= (Q60_W'(h_sycr_reg) <<< SC_W) + Q60_W'(l_sycr_reg);
            q_cycp_reg <= Q60_W'(cycp2_reg) <<< 20;
            q_sycr_reg <= Q60_W'(sycr2_reg) <<< 20;
            q_sysr_reg <= Q60_W'(sysr2_reg) <<< 20;
            q_cycr_reg <= Q60_W'(cycr2_reg) <<< 20;
            q_cysr_reg <= Q60_W'(cysr2_reg) <<< 20;
            q_srcp_reg <= Q60_W'(srcp2_reg) <<< 20;
            q_crcp_reg <= Q60_W'(crcp2_reg) <<< 20;
            q_sycp_reg <= Q60_W'(sycp2_reg) <<< 20;
            q_sp_reg   <= Q60_W'(sp2_reg) <<< 40;
        end
    end

    // stage 4: entry sums
    logic signed [Q60_W-1:0] sum_reg [N_ENT];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg[0] <= q_cycp_reg;
            sum_reg[1] <= q_sycr_reg + t_cysr_reg;
            sum_reg[2] <= q_sysr_reg - t_cycr_reg;
            sum_reg[3] <= -q_sycp_reg;
            sum_reg[4] <= q_cycr_reg - t_sysr_reg;
            sum_reg[5] <= q_cysr_reg + t_sycr_reg;
            sum_reg[6] <= q_sp_reg;
            sum_reg[7] <= -q_srcp_reg;
            sum_reg[8] <= q_crcp_reg;
        end
    end

    for (genvar e = 0; e < N_ENT; e++)
    begin : g_ent
        assign ent[e] = to_q14(sum_reg[e]);
    end

endmodule

>>> hdl/euler321_to_rotation_matrix_unit.sv
// Euler 3-2-1 angles to direction cosine matrix, top level.
// Depends on e321_pkg, e321_sincos_lane, e321_dcm_merge and the assert header.
//
// Usage:
//   Input channel  in_valid / in_stall carries one request: yaw_angle,
//   pitch_angle, roll_angle, each signed Q4.12 radians; any pattern is legal.
//   Output channel out_valid / out_stall carries the nine matrix entries
//   m00..m22, signed Q1.14 clamped to +/-16384.
//   A request moves at a clock edge with valid high and stall low.
//   Throughput: one request per cycle while out_stall does not hold the
//   pipeline; three parallel sine/cosine lanes (reduction + 20 CORDIC stages)
//   feed a four-stage product/sum merge, then the output register.
//   Stall: while a result sits in the output register and out_stall is
//   high, the whole pipeline holds and in_stall is raised; nothing is lost.
//   Reset (rst_n low, async) empties the pipeline and clears out_valid;
//   no state is carried between requests.
module euler321_to_rotation_matrix_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [15:0]   yaw_angle,
    input  logic signed [15:0]   pitch_angle,
    input  logic signed [15:0]   roll_angle,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [15:0]   m00,
    output logic signed [15:0]   m01,
    output logic signed [15:0]   m02,
    output logic signed [15:0]   m10,
    output logic signed [15:0]   m11,
    output logic signed [15:0]   m12,
    output logic signed [15:0]   m20,
    output logic signed [15:0]   m21,
    output logic signed [15:0]   m22
);
    import e321_pkg::*;

    localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

    logic                advance;
    logic [PIPE_LAT-1:0] pipe_valid_reg;
    logic [PIPE_LAT-1:0] pipe_valid_next;
    logic                out_valid_reg;
    sincos_t             yaw_sc, pitch_sc, roll_sc;
    q14_t                ent [N_ENT];
    q14_t                ent_reg [N_ENT];

    // whole pipeline freezes only when the output register is full and held
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    e321_sincos_lane u_lane_yaw (
        .clk     (clk),
        .advance (advance),
        .angle   (yaw_angle),
        .result  (yaw_sc)
    );

    e321_sincos_lane u_lane_pitch (
        .clk     (clk),
        .advance (advance),
        .angle   (pitch_angle),
        .result  (pitch_sc)
    );

    e321_sincos_lane u_lane_roll (
        .clk     (clk),
        .advance (advance),
        .angle   (roll_angle),
        .result  (roll_sc)
    );

    e321_dcm_merge u_merge (
        .clk     (clk),
        .advance (advance),
        .yaw     (yaw_sc),
        .pitch   (pitch_sc),
        .roll    (roll_sc),
        .ent     (ent)
    );

    // valid tag travels alongside the data
    assign pipe_valid_next = {pipe_valid_reg[PIPE_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= pipe_valid_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            ent_reg <= ent;
    end

    assign out_valid = out_valid_reg;
    assign m00 = ent_reg[0];
    assign m01 = ent_reg[1];
    assign m02 = ent_reg[2];
    assign m10 = ent_reg[3];
    assign m11 = ent_reg[4];
    assign m12 = ent_reg[5];
    assign m20 = ent_reg[6];
    assign m21 = ent_reg[7];
    assign m22 = ent_reg[8];

`include "euler321_to_rotation_matrix_unit_assert.svh"

    `E321_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, pipe_valid_reg[0])
    `E321_ASSERT_NEXT(a_hold_freezes, out_valid && out_stall, $stable(pipe_valid_reg))
    `E321_ASSERT_NOW(a_clamped, out_valid, (m00 <= 16'sd16384) && (m00 >= -16'sd16384) && (m22 <= 16'sd16384) && (m22 >= -16'sd16384))

endmodule

>>> tb/euler321_to_rotation_matrix_unit_test.sv
// Testbench for the Euler 3-2-1 to direction cosine matrix unit.
// Depends on e321_pkg and the RTL top level euler321_to_rotation_matrix_unit.
// Drives angle triples with random gaps, stalls the output, checks all nine entries.
module euler321_to_rotation_matrix_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import e321_pkg::*;

    typedef struct {
        logic signed [15:0] ent [9];
    } dcm_t;

    // Sine/cosine of a Q4.12 angle in Q20, bit-exact with the unit's CORDIC.
    function automatic void angle_sincos(input logic signed [15:0] ang,
                                         output longint s, output longint c);
        longint atan_tab [20] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF};
        longint r;
        longint x;
        longint y;
        longint dx;
        longint dy;
        longint cs;
        longint sn;
        int quad;
        r = longint'(ang) * 262144;
        x = 652032874;
        y = 0;
        quad = 0;
        while (r > 64'sh3243F6A8)
        begin
            r -= 64'h6487ED51;
            quad++;
        end
        while (r < -64'sh3243F6A8)
        begin
            r += 64'h6487ED51;
            quad--;
        end
        for (int i = 0; i < 20; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0)
            begin
                x -= dx; y += dy; r -= atan_tab[i];
            end
            else
            begin
                x += dx; y -= dy; r += atan_tab[i];
            end
        end
        case (quad & 3)
            0: begin cs = x;  sn = y;  end
            1: begin cs = -y; sn = x;  end
            2: begin cs = -x; sn = -y; end
            default: begin cs = y; sn = -x; end
        endcase
        s = (sn + 512) >>> 10;
        c = (cs + 512) >>> 10;
    endfunction

    // Q60 to clamped Q14; Q60 sums can exceed 64 bits, so use 80-bit maths.
    function automatic logic signed [15:0] q60_to_q14(input logic signed [79:0] v);
        logic signed [79:0] t;
        t = (v + (80'sd1 <<< 45)) >>> 46;
        if (t > 80'sd16384)
            t = 80'sd16384;
        if (t < -80'sd16384)
            t = -80'sd16384;
        return t[15:0];
    endfunction

    function automatic dcm_t predict_dcm(input logic signed [15:0] yaw,
                                         input logic signed [15:0] pitch,
                                         input logic signed [15:0] roll);
        longint sy, cy, sp, cp, sr, cr;
        logic signed [79:0] k20;
        dcm_t d;
        angle_sincos(yaw, sy, cy);
        angle_sincos(pitch, sp, cp);
        angle_sincos(roll, sr, cr);
        k20 = 80'sd1048576;
        d.ent[0] = q60_to_q14(80'(cy) * cp * k20);
        d.ent[1] = q60_to_q14(80'(sy) * cr * k20 + 80'(cy) * sp * sr);
        d.ent[2] = q60_to_q14(80'(sy) * sr * k20 - 80'(cy) * sp * cr);
        d.ent[3] = q60_to_q14(-(80'(sy) * cp * k20));
        d.ent[4] = q60_to_q14(80'(cy) * cr * k20 - 80'(sy) * sp * sr);
        d.ent[5] = q60_to_q14(80'(cy) * sr * k20 + 80'(sy) * sp * cr);
        d.ent[6] = q60_to_q14(80'(sp) * (80'sd1 <<< 40));
        d.ent[7] = q60_to_q14(-(80'(sr) * cp * k20));
        d.ent[8] = q60_to_q14(80'(cr) * cp * k20);
        return d;
    endfunction

    class dcm_scoreboard;
        dcm_t pending_dcm [$];
        int   mismatches;

        function void note_request(logic signed [15:0] yaw, logic signed [15:0] pitch,
                                   logic signed [15:0] roll);
            pending_dcm.push_back(predict_dcm(yaw, pitch, roll));
        endfunction

        function void check_result(dcm_t got);
            dcm_t want;
            if (pending_dcm.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result with nothing pending");
                return;
            end
            want = pending_dcm.pop_front();
            for (int i = 0; i < 9; i++)
                if (got.ent[i] !== want.ent[i])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("entry m%0d%0d: expected %0d, got %0d",
                                 i / 3, i % 3, want.ent[i], got.ent[i]);
                end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [15:0] yaw_angle = '0;
    logic signed [15:0] pitch_angle = '0;
    logic signed [15:0] roll_angle = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    dcm_scoreboard board = new();
    bit quiet_phase = 1'b0;    // no idling in the last part of the run
    bit long_holdoff = 1'b0;   // receiver holds off to fill the pipeline

    euler321_to_rotation_matrix_unit uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Output side: stall in random bursts, sampled at the edge the unit sees.
    always @(posedge clk)
    begin
        dcm_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.ent = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
            board.check_result(got);
        end
    end

    initial
    begin
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_holdoff)
            begin
                out_stall <= 1'b1;
                repeat (60) @(posedge clk);
                out_stall <= 1'b0;
                long_holdoff = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 4);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one request, hold it until accepted; optionally leave a gap first.
    task automatic send_request(input logic [15:0] yaw, input logic [15:0] pitch,
                                input logic [15:0] roll);
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        yaw_angle   <= yaw;
        pitch_angle <= pitch;
        roll_angle  <= roll;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(yaw, pitch, roll);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 25736)) - 12868); // within +/- pi
            2: return 16'($signed($urandom_range(0, 200)) - 100);     // near zero
            default: return 16'($signed($urandom_range(0, 400)) - 200
                                + ($urandom_range(0, 7) - 4) * 6434); // near quadrant edges
        endcase
    endfunction

    initial
    begin
        logic [15:0] edge_angles [12] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001,
            16'hFFFF, 16'd3217, -16'sd3217, 16'd3216, 16'd6434, -16'sd6434,
            16'd12868, -16'sd12868};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, quarter-turn boundaries, gimbal lock at +/- pi/2
        foreach (edge_angles[i])
            send_request(edge_angles[i], edge_angles[11 - i], edge_angles[(i + 5) % 12]);
        send_request(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_request(16'h8000, 16'h8000, 16'h8000);
        send_request(16'hAAAA, 16'h5555, 16'hAAAA);
        send_request(16'h5555, 16'hAAAA, 16'h5555);
        send_request(16'd1000, 16'd6434, -16'sd2000);
        send_request(-16'sd1000, -16'sd6434, 16'd2000);

        for (int n = 0; n < 1400; n++)
        begin
            if (n == 300)
                long_holdoff = 1'b1;
            if (n == 1200)
                quiet_phase = 1'b1;
            send_request(pick_angle(), pick_angle(), pick_angle());
        end
        in_valid <= 1'b0;

        while (board.pending_dcm.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end
endmodule
